[rtl/swn_pkg.sv]
// shared types and constants for the skin weight normaliser
`timescale 1ns / 1ps
package swn_pkg;
  localparam int VTX_W      = 16;
  localparam int BONE_W     = 8;
  localparam int JNT_W      = 7;
  localparam int WGT_W      = 16;
  localparam int CFG_W      = 8;
  localparam int SQ_W       = 32;
  localparam int SUM_W      = 34;
  localparam int QUO_W      = 31;
  localparam int ROOT_W     = 32;
  localparam int NUM_BONES  = 4;
  localparam int DIV_STEPS  = 31;
  localparam int SQRT_STEPS = 16;
  localparam logic [WGT_W-1:0] ONE_Q15 = 16'h8000;

  typedef struct packed {
    logic [VTX_W-1:0] vertex;
    logic [JNT_W-1:0] joint;
    logic             last;
  } swn_tag_t;
endpackage

[rtl/swn_front.sv]
// input capture, squares, sum and per-bone record issue
`timescale 1ns / 1ps
module swn_front import swn_pkg::*; #(
  parameter int MAX_JOINTS = 128
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  output logic                    busy,
  input  logic [VTX_W-1:0]        in_vertex_id,
  input  logic signed [BONE_W-1:0] in_primary_bone,
  input  logic signed [BONE_W-1:0] in_extra_bone_a,
  input  logic [WGT_W-1:0]        in_extra_weight_a,
  input  logic signed [BONE_W-1:0] in_extra_bone_b,
  input  logic [WGT_W-1:0]        in_extra_weight_b,
  input  logic signed [BONE_W-1:0] in_extra_bone_c,
  input  logic [WGT_W-1:0]        in_extra_weight_c,
  input  logic [CFG_W-1:0]        joint_count,
  output logic                    rec_vld,
  output swn_tag_t                rec_tag,
  output logic [SQ_W-1:0]         rec_w2,
  output logic [SUM_W-1:0]        rec_sum
);
  logic                       accept;
  logic [1:0]                 hold_r, hold_nxt;
  logic                       v0_vld_r, v1_vld_r, v2_vld_r;
  logic [VTX_W-1:0]           vid0_r, vid1_r, vid2_r;
  logic [BONE_W-1:0]          bone0_r [NUM_BONES];
  logic [WGT_W-1:0]           wgt0_r  [NUM_BONES];
  logic [SQ_W-1:0]            sq1_r [NUM_BONES];
  logic [SQ_W-1:0]            sq2_r [NUM_BONES];
  logic [JNT_W-1:0]           jnt1_r [NUM_BONES];
  logic [JNT_W-1:0]           jnt2_r [NUM_BONES];
  logic [NUM_BONES-1:0]       emit1_r, emit2_r, last2_nxt, last2_r, emit1_nxt;
  logic [SUM_W-1:0]           sum2_r;
  logic [1:0]                 cnt_r, cnt_nxt, slot;
  logic                       act_r, act_nxt, issue;
  logic                       rec_vld_r;
  swn_tag_t                   rec_tag_r;
  logic [SQ_W-1:0]            rec_w2_r;
  logic [SUM_W-1:0]           rec_sum_r;

  assign accept = start && !busy;
  assign busy   = (hold_r != 2'd0);

  // busy spaces transactions to match the record issue, so bone walks never overlap
  always_comb begin
    hold_nxt = hold_r;
    if (accept) begin
      hold_nxt = 2'd3;
    end else if (hold_r != 2'd0) begin
      hold_nxt = hold_r - 2'd1;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_BONES; k++) begin
      emit1_nxt[k] = !bone0_r[k][BONE_W-1] && (wgt0_r[k] != '0) &&
                     ({1'b0, bone0_r[k][JNT_W-1:0]} < joint_count) &&
                     (32'(bone0_r[k][JNT_W-1:0]) < 32'(MAX_JOINTS));
    end
    for (int k = 0; k < NUM_BONES; k++) begin
      last2_nxt[k] = emit1_r[k];
      for (int j = k + 1; j < NUM_BONES; j++) begin
        if (emit1_r[j]) begin
          last2_nxt[k] = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r   <= 2'd0;
      v0_vld_r <= 1'b0;
      v1_vld_r <= 1'b0;
      v2_vld_r <= 1'b0;
    end else begin
      hold_r   <= hold_nxt;
      v0_vld_r <= accept;
      v1_vld_r <= v0_vld_r;
      v2_vld_r <= v1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      vid0_r     <= in_vertex_id;
      bone0_r[0] <= in_primary_bone;
      wgt0_r[0]  <= ONE_Q15;
      bone0_r[1] <= in_extra_bone_a;
      wgt0_r[1]  <= in_extra_weight_a;
      bone0_r[2] <= in_extra_bone_b;
      wgt0_r[2]  <= in_extra_weight_b;
      bone0_r[3] <= in_extra_bone_c;
      wgt0_r[3]  <= in_extra_weight_c;
    end
    if (v0_vld_r) begin
      vid1_r  <= vid0_r;
      emit1_r <= emit1_nxt;
      for (int k = 0; k < NUM_BONES; k++) begin
        // negative id drops the bone from the sum
        sq1_r[k]  <= bone0_r[k][BONE_W-1] ? '0 : wgt0_r[k] * wgt0_r[k];
        jnt1_r[k] <= bone0_r[k][JNT_W-1:0];
      end
    end
    if (v1_vld_r) begin
      vid2_r  <= vid1_r;
      emit2_r <= emit1_r;
      last2_r <= last2_nxt;
      sum2_r  <= SUM_W'(sq1_r[0]) + SUM_W'(sq1_r[1]) + SUM_W'(sq1_r[2]) + SUM_W'(sq1_r[3]);
      for (int k = 0; k < NUM_BONES; k++) begin
        sq2_r[k]  <= sq1_r[k];
        jnt2_r[k] <= jnt1_r[k];
      end
    end
  end

  // walk the four bones, one per cycle
  always_comb begin
    issue   = v2_vld_r || act_r;
    slot    = v2_vld_r ? 2'd0 : cnt_r;
    cnt_nxt = cnt_r;
    act_nxt = act_r;
    if (issue) begin
      cnt_nxt = slot + 2'd1;
      act_nxt = (slot != 2'd3);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= 2'd0;
      act_r     <= 1'b0;
      rec_vld_r <= 1'b0;
    end else begin
      cnt_r     <= cnt_nxt;
      act_r     <= act_nxt;
      rec_vld_r <= issue && emit2_r[slot];
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rec_tag_r.vertex <= vid2_r;
      rec_tag_r.joint  <= jnt2_r[slot];
      rec_tag_r.last   <= last2_r[slot];
      rec_w2_r         <= sq2_r[slot];
      rec_sum_r        <= sum2_r;
    end
  end

  assign rec_vld = rec_vld_r;
  assign rec_tag = rec_tag_r;
  assign rec_w2  = rec_w2_r;
  assign rec_sum = rec_sum_r;
endmodule

[rtl/swn_divider.sv]
// restoring divider, one quotient bit per stage: floor(w2 * 2^30 / sum)
`timescale 1ns / 1ps
module swn_divider import swn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  swn_tag_t          in_tag,
  input  logic [SQ_W-1:0]   in_w2,
  input  logic [SUM_W-1:0]  in_sum,
  output logic              out_vld,
  output swn_tag_t          out_tag,
  output logic [QUO_W-1:0]  out_quo
);
  logic             vld_r [DIV_STEPS];
  swn_tag_t         tag_r [DIV_STEPS];
  logic [SUM_W-1:0] rem_r [DIV_STEPS];
  logic [SUM_W-1:0] sum_r [DIV_STEPS];
  logic [QUO_W-1:0] quo_r [DIV_STEPS];

  logic [SUM_W-1:0] rem_in  [DIV_STEPS];
  logic [SUM_W-1:0] sum_in  [DIV_STEPS];
  logic [QUO_W-1:0] quo_in  [DIV_STEPS];
  logic             nbit    [DIV_STEPS];
  logic [SUM_W:0]   trial   [DIV_STEPS];
  logic             ge      [DIV_STEPS];
  logic [SUM_W-1:0] rem_nxt [DIV_STEPS];
  logic [QUO_W-1:0] quo_nxt [DIV_STEPS];

  // w2 <= sum, so the top part w2 >> 1 already sits below the divisor
  always_comb begin
    for (int s = 0; s < DIV_STEPS; s++) begin
      if (s == 0) begin
        rem_in[s] = SUM_W'(in_w2[SQ_W-1:1]);
        sum_in[s] = in_sum;
        quo_in[s] = '0;
        nbit[s]   = in_w2[0];
      end else begin
        rem_in[s] = rem_r[s-1];
        sum_in[s] = sum_r[s-1];
        quo_in[s] = quo_r[s-1];
        nbit[s]   = 1'b0;
      end
      trial[s]   = {rem_in[s], nbit[s]};
      ge[s]      = (trial[s] >= {1'b0, sum_in[s]});
      rem_nxt[s] = ge[s] ? SUM_W'(trial[s] - {1'b0, sum_in[s]}) : trial[s][SUM_W-1:0];
      quo_nxt[s] = {quo_in[s][QUO_W-2:0], ge[s]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < DIV_STEPS; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int s = 1; s < DIV_STEPS; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    for (int s = 1; s < DIV_STEPS; s++) begin
      tag_r[s] <= tag_r[s-1];
    end
    for (int s = 0; s < DIV_STEPS; s++) begin
      rem_r[s] <= rem_nxt[s];
      sum_r[s] <= sum_in[s];
      quo_r[s] <= quo_nxt[s];
    end
  end

  assign out_vld = vld_r[DIV_STEPS-1];
  assign out_tag = tag_r[DIV_STEPS-1];
  assign out_quo = quo_r[DIV_STEPS-1];
endmodule

[rtl/swn_isqrt.sv]
// digit-by-digit integer square root, one result bit per stage
`timescale 1ns / 1ps
module swn_isqrt import swn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_vld,
  input  swn_tag_t          in_tag,
  input  logic [QUO_W-1:0]  in_x,
  output logic              out_vld,
  output swn_tag_t          out_tag,
  output logic [WGT_W-1:0]  out_root
);
  logic              vld_r [SQRT_STEPS];
  swn_tag_t          tag_r [SQRT_STEPS];
  logic [QUO_W-1:0]  x_r   [SQRT_STEPS];
  logic [ROOT_W-1:0] r_r   [SQRT_STEPS];

  logic [QUO_W-1:0]  x_in  [SQRT_STEPS];
  logic [ROOT_W-1:0] r_in  [SQRT_STEPS];
  logic [ROOT_W-1:0] bitv  [SQRT_STEPS];
  logic [ROOT_W-1:0] trial [SQRT_STEPS];
  logic [QUO_W-1:0]  x_nxt [SQRT_STEPS];
  logic [ROOT_W-1:0] r_nxt [SQRT_STEPS];

  always_comb begin
    for (int s = 0; s < SQRT_STEPS; s++) begin
      x_in[s]  = (s == 0) ? in_x : x_r[(s == 0) ? 0 : s-1];
      r_in[s]  = (s == 0) ? '0   : r_r[(s == 0) ? 0 : s-1];
      bitv[s]  = ROOT_W'(1) << (QUO_W - 1 - 2 * s);
      trial[s] = r_in[s] + bitv[s];
      if (ROOT_W'(x_in[s]) >= trial[s]) begin
        x_nxt[s] = QUO_W'(ROOT_W'(x_in[s]) - trial[s]);
        r_nxt[s] = (r_in[s] >> 1) + bitv[s];
      end else begin
        x_nxt[s] = x_in[s];
        r_nxt[s] = r_in[s] >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < SQRT_STEPS; s++) begin
        vld_r[s] <= 1'b0;
      end
    end else begin
      vld_r[0] <= in_vld;
      for (int s = 1; s < SQRT_STEPS; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    tag_r[0] <= in_tag;
    for (int s = 1; s < SQRT_STEPS; s++) begin
      tag_r[s] <= tag_r[s-1];
    end
    for (int s = 0; s < SQRT_STEPS; s++) begin
      x_r[s] <= x_nxt[s];
      r_r[s] <= r_nxt[s];
    end
  end

  assign out_vld  = vld_r[SQRT_STEPS-1];
  assign out_tag  = tag_r[SQRT_STEPS-1];
  assign out_root = r_r[SQRT_STEPS-1][WGT_W-1:0];
endmodule

[rtl/skin_weight_normalizer.sv]
// top level of the skin weight normaliser
`timescale 1ns / 1ps
// usage
//   a vertex transaction is taken when start is high and busy is low; busy
//   then rises, spacing vertices so that their bone walks never overlap
//   each vertex issues its four bones in turn (primary, a, b, c) into a
//   pipeline: capture, squares, sum, issue, a 31-stage divider and a
//   16-stage square root. records leave in bone order; bones that do not
//   emit leave an empty slot
//   records appear for one cycle with out_valid high; out_last marks the
//   final record of a vertex. the receiver cannot stall, nothing holds back
//   cfg_we with cfg_data writes the joint count; write it only while idle
//   synchronous reset clears the joint count, busy and every valid bit;
//   transactions in flight are dropped
module skin_weight_normalizer import swn_pkg::*; #(
  parameter int MAX_JOINTS = 128
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic [VTX_W-1:0]         in_vertex_id,
  input  logic signed [BONE_W-1:0] in_primary_bone,
  input  logic signed [BONE_W-1:0] in_extra_bone_a,
  input  logic [WGT_W-1:0]         in_extra_weight_a,
  input  logic signed [BONE_W-1:0] in_extra_bone_b,
  input  logic [WGT_W-1:0]         in_extra_weight_b,
  input  logic signed [BONE_W-1:0] in_extra_bone_c,
  input  logic [WGT_W-1:0]         in_extra_weight_c,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_data,
  output logic                     out_valid,
  output logic [VTX_W-1:0]         out_vertex,
  output logic [JNT_W-1:0]         out_joint_index,
  output logic [WGT_W-1:0]         out_norm_weight,
  output logic                     out_last
);
  logic [CFG_W-1:0] joint_count_r;
  logic             rec_vld, div_vld, sq_vld;
  swn_tag_t         rec_tag, div_tag, sq_tag;
  logic [SQ_W-1:0]  rec_w2;
  logic [SUM_W-1:0] rec_sum;
  logic [QUO_W-1:0] div_quo;
  logic [WGT_W-1:0] sq_root;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      joint_count_r <= '0;
    end else if (cfg_we) begin
      joint_count_r <= cfg_data;
    end
  end

  swn_front #(.MAX_JOINTS(MAX_JOINTS)) u_front (
    .clk, .rst_n, .start, .busy,
    .in_vertex_id, .in_primary_bone,
    .in_extra_bone_a, .in_extra_weight_a,
    .in_extra_bone_b, .in_extra_weight_b,
    .in_extra_bone_c, .in_extra_weight_c,
    .joint_count(joint_count_r),
    .rec_vld, .rec_tag, .rec_w2, .rec_sum
  );

  swn_divider u_div (
    .clk, .rst_n,
    .in_vld(rec_vld), .in_tag(rec_tag), .in_w2(rec_w2), .in_sum(rec_sum),
    .out_vld(div_vld), .out_tag(div_tag), .out_quo(div_quo)
  );

  swn_isqrt u_sqrt (
    .clk, .rst_n,
    .in_vld(div_vld), .in_tag(div_tag), .in_x(div_quo),
    .out_vld(sq_vld), .out_tag(sq_tag), .out_root(sq_root)
  );

  assign out_valid       = sq_vld;
  assign out_vertex      = sq_tag.vertex;
  assign out_joint_index = sq_tag.joint;
  assign out_norm_weight = sq_root;
  assign out_last        = sq_tag.last;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy not raised after transaction");
  a_weight_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_norm_weight <= ONE_Q15))
    else $error("normalised weight above one");
  a_joint_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, out_joint_index} < joint_count_r))
    else $error("record for joint outside skeleton");
`endif
endmodule

[tb/tb_skin_weight_normalizer.sv]
// self-checking testbench for the skin weight normaliser
`timescale 1ns / 1ps
module tb_skin_weight_normalizer;
  import swn_pkg::*;

  localparam int DRAIN_CYCLES = 70;
  localparam int STALL_LIMIT  = 4000;
  localparam int JOINT_LIMIT  = 128;

  typedef struct {
    logic [VTX_W-1:0]         vertex;
    logic signed [BONE_W-1:0] bone [NUM_BONES];
    logic [WGT_W-1:0]         weight [NUM_BONES];
  } vertex_t;

  typedef struct {
    logic [VTX_W-1:0] vertex;
    logic [JNT_W-1:0] joint;
    logic [WGT_W-1:0] weight;
    logic             last;
  } bind_rec_t;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic [VTX_W-1:0]         in_vertex_id;
  logic signed [BONE_W-1:0] in_primary_bone;
  logic signed [BONE_W-1:0] in_extra_bone_a;
  logic [WGT_W-1:0]         in_extra_weight_a;
  logic signed [BONE_W-1:0] in_extra_bone_b;
  logic [WGT_W-1:0]         in_extra_weight_b;
  logic signed [BONE_W-1:0] in_extra_bone_c;
  logic [WGT_W-1:0]         in_extra_weight_c;
  logic                     cfg_we;
  logic [CFG_W-1:0]         cfg_data;
  logic                     out_valid;
  logic [VTX_W-1:0]         out_vertex;
  logic [JNT_W-1:0]         out_joint_index;
  logic [WGT_W-1:0]         out_norm_weight;
  logic                     out_last;

  vertex_t          vertex_q [$];
  bind_rec_t        bind_q [$];
  logic [CFG_W-1:0] joint_count_model;
  int               idle_pct;
  int               error_count;
  int               stall_cycles;

  skin_weight_normalizer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_vertex_id     (in_vertex_id),
    .in_primary_bone  (in_primary_bone),
    .in_extra_bone_a  (in_extra_bone_a),
    .in_extra_weight_a(in_extra_weight_a),
    .in_extra_bone_b  (in_extra_bone_b),
    .in_extra_weight_b(in_extra_weight_b),
    .in_extra_bone_c  (in_extra_bone_c),
    .in_extra_weight_c(in_extra_weight_c),
    .cfg_we           (cfg_we),
    .cfg_data         (cfg_data),
    .out_valid        (out_valid),
    .out_vertex       (out_vertex),
    .out_joint_index  (out_joint_index),
    .out_norm_weight  (out_norm_weight),
    .out_last         (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    error_count++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned root;
    longint unsigned bitv;
    root = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    return root;
  endfunction

  // l2-normalise the counted weights and queue one record per bone in range
  task automatic predict_bindings(input vertex_t v);
    longint unsigned w [NUM_BONES];
    bit              counted [NUM_BONES];
    longint unsigned sum_sq;
    int              lim;
    bind_rec_t       rec;
    int              first_new;
    sum_sq = 0;
    lim = (joint_count_model < JOINT_LIMIT) ? joint_count_model : JOINT_LIMIT;
    first_new = bind_q.size();
    for (int k = 0; k < NUM_BONES; k++) begin
      w[k] = (k == 0) ? 64'd32768 : 64'(v.weight[k]);
      counted[k] = (v.bone[k] >= 0) && (w[k] != 0);
      if (counted[k]) sum_sq += w[k] * w[k];
    end
    for (int k = 0; k < NUM_BONES; k++) begin
      if (counted[k] && int'(v.bone[k]) < lim && sum_sq != 0) begin
        rec.vertex = v.vertex;
        rec.joint  = v.bone[k][JNT_W-1:0];
        rec.weight = WGT_W'(int_sqrt(((w[k] * w[k]) << 30) / sum_sq));
        rec.last   = 1'b0;
        bind_q.push_back(rec);
      end
    end
    if (bind_q.size() > first_new) bind_q[bind_q.size()-1].last = 1'b1;
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!start || !busy) begin
      if (vertex_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
        vertex_t v;
        v = vertex_q.pop_front();
        start             <= 1'b1;
        in_vertex_id      <= v.vertex;
        in_primary_bone   <= v.bone[0];
        in_extra_bone_a   <= v.bone[1];
        in_extra_weight_a <= v.weight[1];
        in_extra_bone_b   <= v.bone[2];
        in_extra_weight_b <= v.weight[2];
        in_extra_bone_c   <= v.bone[3];
        in_extra_weight_c <= v.weight[3];
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: predict on each accepted vertex, check each record
  always @(posedge clk) begin
    if (!rst_n) begin
      joint_count_model <= '0;
      stall_cycles <= 0;
    end else begin
      if (cfg_we) joint_count_model <= cfg_data;
      if (start && !busy) begin
        vertex_t v;
        v.vertex = in_vertex_id;
        v.bone[0] = in_primary_bone;   v.weight[0] = ONE_Q15;
        v.bone[1] = in_extra_bone_a;   v.weight[1] = in_extra_weight_a;
        v.bone[2] = in_extra_bone_b;   v.weight[2] = in_extra_weight_b;
        v.bone[3] = in_extra_bone_c;   v.weight[3] = in_extra_weight_c;
        predict_bindings(v);
      end
      if (out_valid) begin
        if (bind_q.size() == 0) begin
          report_mismatch($sformatf("unexpected record vertex %0h joint %0d",
                                    out_vertex, out_joint_index));
        end else begin
          bind_rec_t exp_rec;
          exp_rec = bind_q.pop_front();
          if (out_vertex !== exp_rec.vertex)
            report_mismatch($sformatf("vertex %0h, want %0h", out_vertex,
                                      exp_rec.vertex));
          if (out_joint_index !== exp_rec.joint)
            report_mismatch($sformatf("joint %0d, want %0d", out_joint_index,
                                      exp_rec.joint));
          if (out_norm_weight !== exp_rec.weight)
            report_mismatch($sformatf("weight %0h, want %0h (vertex %0h)",
                                      out_norm_weight, exp_rec.weight, exp_rec.vertex));
          if (out_last !== exp_rec.last)
            report_mismatch($sformatf("last %0b, want %0b", out_last, exp_rec.last));
        end
      end
      if ((start && !busy) || out_valid || cfg_we) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_skin_weight_normalizer: done, errors");
        $finish;
      end
    end
  end

  function automatic logic signed [BONE_W-1:0] rand_bone(input int jc);
    int top;
    top = (jc == 0 || jc > 128) ? 127 : jc;
    case ($urandom_range(0, 9))
      0: return BONE_W'($urandom);
      1: return -BONE_W'($urandom_range(1, 128));
      2: return BONE_W'($urandom_range(top > 127 ? 127 : top, 127));
      default: return BONE_W'($urandom_range(0, top > 127 ? 127 : top));
    endcase
  endfunction

  function automatic logic [WGT_W-1:0] rand_weight();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'hFFFF;
      2: return WGT_W'($urandom_range(1, 255));
      default: return WGT_W'($urandom);
    endcase
  endfunction

  function automatic vertex_t make_vertex(input logic [VTX_W-1:0] vid,
                                          input int b0, input int b1, input int w1,
                                          input int b2, input int w2,
                                          input int b3, input int w3);
    vertex_t v;
    v.vertex = vid;
    v.bone[0] = BONE_W'(b0); v.weight[0] = ONE_Q15;
    v.bone[1] = BONE_W'(b1); v.weight[1] = WGT_W'(w1);
    v.bone[2] = BONE_W'(b2); v.weight[2] = WGT_W'(w2);
    v.bone[3] = BONE_W'(b3); v.weight[3] = WGT_W'(w3);
    return v;
  endfunction

  task automatic wait_idle();
    while (vertex_q.size() != 0 || start || bind_q.size() != 0) @(posedge clk);
    // vertices with no record may still be in the pipeline
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_joint_count(input logic [CFG_W-1:0] value);
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_phase(input logic [CFG_W-1:0] jc, input int count, input int pct);
    vertex_t v;
    wait_idle();
    write_joint_count(jc);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      v.vertex = VTX_W'($urandom);
      v.weight[0] = ONE_Q15;
      for (int k = 0; k < NUM_BONES; k++) begin
        v.bone[k] = rand_bone(jc);
        if (k != 0) v.weight[k] = rand_weight();
      end
      vertex_q.push_back(v);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    cfg_we = 1'b0;
    cfg_data = '0;
    in_vertex_id = '0;
    in_primary_bone = '0;
    in_extra_bone_a = '0;
    in_extra_weight_a = '0;
    in_extra_bone_b = '0;
    in_extra_weight_b = '0;
    in_extra_bone_c = '0;
    in_extra_weight_c = '0;
    idle_pct = 24;
    error_count = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // joint count still zero from reset: bones count but nothing is emitted
    for (int i = 0; i < 6; i++)
      vertex_q.push_back(make_vertex(VTX_W'($urandom), i, 1, 16'h4000, 2, 16'h8000,
                                     127, 16'hFFFF));

    wait_idle();
    write_joint_count(8'd128);
    vertex_q.push_back(make_vertex(16'h0000, 0, -1, 0, -1, 0, -1, 0));
    vertex_q.push_back(make_vertex(16'hFFFF, 127, 0, 16'hFFFF, 1, 16'hFFFF, 2, 16'hFFFF));
    // no counted bone at all
    vertex_q.push_back(make_vertex(16'h1234, -1, -128, 16'hFFFF, -5, 16'h8000, -1, 1));
    // zero weights do not count even with valid ids
    vertex_q.push_back(make_vertex(16'h5555, 3, 4, 0, 5, 0, 6, 0));
    vertex_q.push_back(make_vertex(16'hAAAA, -1, 7, 1, -1, 0, -1, 0));
    vertex_q.push_back(make_vertex(16'h0001, -128, 127, 16'h8000, 0, 16'h8000, 64, 1));
    vertex_q.push_back(make_vertex(16'h8000, 10, 10, 16'h8000, 10, 16'h8000, 10, 16'h8000));
    vertex_q.push_back(make_vertex(16'h7FFF, 1, 2, 1, 3, 1, 4, 1));
    vertex_q.push_back(make_vertex(16'h00FF, -1, 5, 16'hFFFF, 6, 1, -1, 16'hFFFF));
    vertex_q.push_back(make_vertex(16'hFF00, 127, -1, 16'h1234, 126, 16'h7FFF, 125, 16'hFFFE));

    // small limit: id equal to limit is skipped but still weighs in the sum
    wait_idle();
    write_joint_count(8'd5);
    vertex_q.push_back(make_vertex(16'h0042, 5, 4, 16'h8000, 0, 16'h4000, 6, 16'hFFFF));
    vertex_q.push_back(make_vertex(16'h0043, 4, 5, 16'h8000, 3, 16'h2000, 127, 16'h100));
    vertex_q.push_back(make_vertex(16'h0044, 100, 1, 16'hFFFF, -1, 16'hFFFF, 2, 16'h8000));

    // joint counts above the maximum act as the maximum
    wait_idle();
    write_joint_count(8'd255);
    vertex_q.push_back(make_vertex(16'h0100, 127, 126, 16'hFFFF, -1, 0, 0, 16'h0001));
    vertex_q.push_back(make_vertex(16'h0101, -2, 127, 16'h0001, -1, 0, -1, 0));

    random_phase(8'd255, 45, 24);
    random_phase(8'd1, 30, 48);
    random_phase(8'd40, 50, 48);
    random_phase(8'd0, 10, 0);
    random_phase(8'd128, 60, 0);
    random_phase(8'd200, 20, 0);

    wait_idle();
    if (bind_q.size() != 0) report_mismatch("records still outstanding");
    if (error_count == 0) begin
      $display("tb_skin_weight_normalizer: done, clean");
    end else begin
      $display("tb_skin_weight_normalizer: done, errors");
    end
    $finish;
  end
endmodule
